FILE: rtl/rtoi_pkg.sv
// ----------------------------------------------------------------------------
// rtoi_pkg: shared types and constants for the radix text-to-integer parser
// Word formats for the character and result channels, status and register
// codes, and the character codes the parser recognises.
// ----------------------------------------------------------------------------
package rtoi_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 16;
    localparam int unsigned CFG_INDEX_BITS        = 4;
    localparam int unsigned CFG_DATA_BITS         = 8;
    localparam int unsigned RADIX_BITS            = 6;
    localparam int unsigned MAG_BITS              = 31;
    localparam int unsigned CONSUMED_BITS         = 16;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UPPER = 8'd65;
    localparam logic [7:0] CH_LOWER = 8'd97;
    localparam logic [7:0] LETTERS  = 8'd26;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RADIX = 4'd0,
        CFG_CAPS  = 4'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0]       value;
        logic [CONSUMED_BITS-1:0] consumed;
        t_status                  status;
    } t_out_word;

    // Classification of one character against the current radix and case
    typedef struct packed {
        logic            is_nul;
        logic            is_space;
        logic            is_sign;
        logic            is_minus;
        logic            digit_ok;
        logic [5:0]      digit;
    } t_char_class;

endpackage

FILE: rtl/rtoi_digit.sv
// ----------------------------------------------------------------------------
// rtoi_digit: character classifier
// Flags terminators and signs, and gives the digit value of a character
// when it is a legal digit in the given radix and letter case.
// ----------------------------------------------------------------------------
module rtoi_digit (
    input  logic [7:0]                    i_ch,
    input  logic [rtoi_pkg::RADIX_BITS-1:0] i_radix,
    input  logic                          i_caps,
    output rtoi_pkg::t_char_class         o_class
);
    import rtoi_pkg::*;

    logic [7:0] first;
    logic [7:0] num_off;
    logic [7:0] let_off;
    logic       is_num;
    logic       is_let;
    logic [5:0] dval;

    always_comb begin
        first   = i_caps ? CH_UPPER : CH_LOWER;
        num_off = i_ch - CH_ZERO;
        let_off = i_ch - first;
        is_num  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_let  = (i_ch >= first) && (let_off < LETTERS);
        dval    = is_num ? num_off[5:0] : (let_off[5:0] + LETTER_BASE);

        o_class.is_nul   = (i_ch == CH_NUL);
        o_class.is_space = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_class.is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_class.is_minus = (i_ch == CH_MINUS);
        o_class.digit_ok = (is_num || is_let) && (dval < i_radix);
        o_class.digit    = dval;
    end

endmodule

FILE: rtl/rtoi_accum.sv
// ----------------------------------------------------------------------------
// rtoi_accum: parse state and single-step update
// Holds phase, magnitude, sign and position; works out one character per
// step and raises a result when the token ends.
// ----------------------------------------------------------------------------
module rtoi_accum #(
    parameter int unsigned POSITION_BITS = rtoi_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  rtoi_pkg::t_in_word              i_word,
    input  logic [rtoi_pkg::RADIX_BITS-1:0] i_radix,
    input  logic                            i_caps,
    output logic                            o_emit,
    output rtoi_pkg::t_out_word             o_result
);
    import rtoi_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    localparam int unsigned CW  = (POSITION_BITS > CONSUMED_BITS) ? POSITION_BITS
                                                                  : CONSUMED_BITS;
    localparam int unsigned PRW = MAG_BITS + RADIX_BITS;

    t_phase                   r_phase, n_phase;
    logic [MAG_BITS-1:0]      r_mag, n_mag;
    logic                     r_neg, n_neg;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    t_phase                   cur_phase;
    logic [MAG_BITS-1:0]      cur_mag;
    logic                     cur_neg;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [CW-1:0]            pos_ext;
    logic [PRW-1:0]           product;
    logic [PRW-1:0]           next_mag;
    logic [31:0]              mag_ext;
    t_char_class              cls;

    rtoi_digit u_digit (
        .i_ch    (i_word.ch),
        .i_radix (i_radix),
        .i_caps  (i_caps),
        .o_class (cls)
    );

    always_comb begin
        // a start request clears the state before the character is seen
        cur_phase = i_word.start_req ? PH_SKIP : r_phase;
        cur_mag   = i_word.start_req ? '0 : r_mag;
        cur_neg   = i_word.start_req ? 1'b0 : r_neg;
        cur_pos   = i_word.start_req ? '0 : r_pos;

        pos_inc  = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;
        pos_ext  = CW'(cur_pos);
        product  = PRW'(cur_mag) * PRW'(i_radix);
        next_mag = product + PRW'(cls.digit);
        mag_ext  = {1'b0, cur_mag};

        n_phase = cur_phase;
        n_mag   = cur_mag;
        n_neg   = cur_neg;
        n_pos   = cur_pos;
        o_emit  = 1'b0;

        o_result.value    = '0;
        o_result.status   = ST_OK;
        o_result.consumed = (pos_ext > CW'({CONSUMED_BITS{1'b1}}))
                          ? {CONSUMED_BITS{1'b1}} : pos_ext[CONSUMED_BITS-1:0];

        case (cur_phase)
            PH_SKIP, PH_DIGITS: begin
                if (cur_phase == PH_SKIP && cls.is_space) begin
                    n_pos = pos_inc;
                end else if (cur_phase == PH_SKIP && cls.is_nul) begin
                    o_emit  = 1'b1;
                    n_phase = PH_DONE;
                end else if (cur_phase == PH_SKIP && cls.is_sign) begin
                    n_phase = PH_DIGITS;
                    n_neg   = cls.is_minus;
                    n_pos   = pos_inc;
                end else if (cls.is_nul || cls.is_space) begin
                    o_emit         = 1'b1;
                    n_phase        = PH_DONE;
                    o_result.value = cur_neg ? -mag_ext : mag_ext;
                end else if (!cls.digit_ok) begin
                    o_emit          = 1'b1;
                    n_phase         = PH_DONE;
                    o_result.status = ST_INVALID;
                end else if (next_mag[PRW-1:MAG_BITS] != '0) begin
                    o_emit          = 1'b1;
                    n_phase         = PH_DONE;
                    o_result.status = ST_OVERFLOW;
                end else begin
                    n_phase = PH_DIGITS;
                    n_mag   = next_mag[MAG_BITS-1:0];
                    n_pos   = pos_inc;
                end
            end
            default: begin
                // finished: hold until the next start request
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_pos   <= n_pos;
        end
    end

endmodule

FILE: rtl/radix_text_to_integer_parser_core.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser_core: streaming radix string-to-integer parser
// Takes one character word at a time and emits a signed value, a consumed
// count and a status word when a token ends.
//
//   channel  direction  handshake                 word
//   in       slave      i_in_valid / o_in_ready   t_in_word  {ch, start_req}
//   out      master     o_out_valid / i_out_ready t_out_word {value, consumed, status}
//   cfg      slave      i_cfg_valid / o_cfg_ready index + data, 0 radix, 1 capitals
//
// One character word per cycle sustained while no held result stalls it; a result
// passes from its character through the input register, then the result register.
// The multiply-add of magnitude by radix sits between these two registers.
// Reset is synchronous and returns the parse to whitespace skipping, radix
// ten and lower-case letters. A held result stalls the input register only
// when the waiting character would itself produce a result.
// ----------------------------------------------------------------------------
module radix_text_to_integer_parser_core #(
    parameter int unsigned POSITION_BITS = rtoi_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rtoi_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rtoi_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rtoi_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rtoi_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import rtoi_pkg::*;

    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_caps;
    logic [RADIX_BITS-1:0] radix_eff;

    logic      r_in_vld;
    t_in_word  r_in_word;
    logic      r_out_vld;
    t_out_word r_out_word;

    logic      emit;
    t_out_word result;
    logic      out_free;
    logic      step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_caps  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RADIX: r_radix <= i_cfg_data[RADIX_BITS-1:0];
                CFG_CAPS:  r_caps  <= i_cfg_data[0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign radix_eff = ((r_radix < RADIX_MIN) || (r_radix > RADIX_MAX)) ? RADIX_RESET
                                                                        : r_radix;

    rtoi_accum #(
        .POSITION_BITS (POSITION_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_radix  (radix_eff),
        .i_caps   (r_caps),
        .o_emit   (emit),
        .o_result (result)
    );

    assign out_free   = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && (out_free || !emit);
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step && emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers: load the word on acceptance, the result on emission
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_data;
        end
        if (step && emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_word;

endmodule
